// ===== design/sha1_message_digest_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-1 digest assertion macros
// Shared concurrent assertion helpers, sampled on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property holds at every edge outside reset
`define SHA1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHA1_ASSERT(lbl, prop, msg)
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Types, constants and small helper functions shared by the SHA-1 modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  localparam int WORDS       = 5;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 80;

  typedef logic [31:0]                  word_t;
  typedef logic [WORDS-1:0][31:0]       chain_t;
  typedef logic [BLOCK_WORDS-1:0][31:0] block_t;

  // request kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_LAST = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [5:0] LEN_BYTE_POS = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_WAIT
  } state_e;

  // sequencer to compression unit
  typedef struct packed {
    logic start;
    logic init_chain;
  } core_ctrl_t;

  // initial chaining value, word 0 is h0
  function automatic chain_t chain_init();
    chain_t c;
    c[0] = 32'h67452301;
    c[1] = 32'hEFCDAB89;
    c[2] = 32'h98BADCFE;
    c[3] = 32'h10325476;
    c[4] = 32'hC3D2E1F0;
    return c;
  endfunction

  // round constant per group of twenty rounds
  function automatic word_t round_const(input logic [1:0] grp);
    word_t k;
    unique case (grp)
      2'd0:    k = 32'h5A827999;
      2'd1:    k = 32'h6ED9EBA1;
      2'd2:    k = 32'h8F1BBCDC;
      default: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== design/sha1_req_if.sv =====
// ----------------------------------------------------------------------------
// SHA-1 request channel
// Valid/ready channel carrying one message byte or an end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== design/sha1_dig_if.sv =====
// ----------------------------------------------------------------------------
// SHA-1 digest channel
// Valid/ready channel carrying one 32-bit word of the digest.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

// ===== design/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-stream SHA-1 with padding, length append and word-serial digest out.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle and packed big-endian into a 64-byte
// block line. A full block is handed to the compression unit, which runs 80
// rounds on one round datapath and then the chaining add; bytes of the next
// block keep flowing meanwhile. The request channel stalls while a message
// end is padded and its digest loaded, and when a block fills before the
// previous compression is done; the filling byte is taken once the unit is
// no longer busy. At the end of a message the sequencer inserts 0x80, zeros
// and the 8-byte bit length at one byte per cycle, stalling alike on a full
// block and pausing in the zero fill at the length slot (one or two more
// compressions), waits for the last block and a free output stage, and
// loads the five digest words, h0 first, into an output stage that drains
// independently while the next message is taken. No clearing pass after reset.
`default_nettype none
`include "sha1_message_digest_defines.svh"

module sha1_message_digest (
  input  wire          clk_i,
  input  wire          rst_ni,
  sha1_req_if.sink     req_i,
  sha1_dig_if.source   dig_o
);

  sha1_pkg::state_e     state_q, state_d;
  sha1_pkg::block_t     buf_q, buf_d;
  logic [5:0]           byte_cnt_q, byte_cnt_d;
  logic [63:0]          bit_cnt_q, bit_cnt_d;
  logic [2:0]           len_cnt_q, len_cnt_d;
  sha1_pkg::chain_t     out_q, out_d;
  logic [2:0]           out_idx_q, out_idx_d;
  logic                 out_busy_q, out_busy_d;

  logic                 push, push_ok, snap;
  logic [7:0]           push_byte;
  logic                 core_busy;
  sha1_pkg::chain_t     chain;
  sha1_pkg::core_ctrl_t core_ctrl;
  logic [519:0]         shifted;

  // a push that fills the block needs the compression unit free
  assign push_ok = !((byte_cnt_q == 6'd63) && core_busy);

  // sequencer: request intake and padding
  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    len_cnt_d = len_cnt_q;
    push      = 1'b0;
    push_byte = 8'h00;
    snap      = 1'b0;
    req_i.ready = 1'b0;
    unique case (state_q)
      sha1_pkg::ST_IDLE: begin
        req_i.ready = push_ok;
        if (req_i.valid && push_ok) begin
          if (req_i.kind == sha1_pkg::KIND_BYTE || req_i.kind == sha1_pkg::KIND_LAST) begin
            push      = 1'b1;
            push_byte = req_i.data_byte;
            bit_cnt_d = bit_cnt_q + 64'd8;
          end
          if (req_i.kind == sha1_pkg::KIND_LAST || req_i.kind == sha1_pkg::KIND_END) begin
            state_d = sha1_pkg::ST_PAD_MARK;
          end
        end
      end
      sha1_pkg::ST_PAD_MARK: begin
        if (push_ok) begin
          push      = 1'b1;
          push_byte = sha1_pkg::PAD_MARK;
          state_d   = sha1_pkg::ST_PAD_ZERO;
        end
      end
      sha1_pkg::ST_PAD_ZERO: begin
        // zero fill, wrapping through a full block when past the length slot
        if (byte_cnt_q == sha1_pkg::LEN_BYTE_POS) begin
          len_cnt_d = '0;
          state_d   = sha1_pkg::ST_PAD_LEN;
        end else if (push_ok) begin
          push = 1'b1;
        end
      end
      sha1_pkg::ST_PAD_LEN: begin
        // length bytes, most significant first; count ends cleared
        if (push_ok) begin
          push      = 1'b1;
          push_byte = bit_cnt_q[63:56];
          bit_cnt_d = {bit_cnt_q[55:0], 8'h00};
          len_cnt_d = len_cnt_q + 3'd1;
          if (len_cnt_q == 3'd7) begin
            state_d = sha1_pkg::ST_WAIT;
          end
        end
      end
      sha1_pkg::ST_WAIT: begin
        if (!core_busy && !out_busy_q) begin
          snap    = 1'b1;
          state_d = sha1_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  // block packing
  assign shifted = {buf_q, push_byte};
  always_comb begin
    buf_d      = buf_q;
    byte_cnt_d = byte_cnt_q;
    if (push) begin
      buf_d      = shifted[511:0];
      byte_cnt_d = byte_cnt_q + 6'd1;
    end
  end

  assign core_ctrl.start      = push && (byte_cnt_q == 6'd63);
  assign core_ctrl.init_chain = snap;

  sha1_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (core_ctrl),
    .block_i(buf_d),
    .busy_o (core_busy),
    .chain_o(chain)
  );

  // digest output stage
  always_comb begin
    out_d      = out_q;
    out_idx_d  = out_idx_q;
    out_busy_d = out_busy_q;
    if (snap) begin
      out_d      = chain;
      out_idx_d  = '0;
      out_busy_d = 1'b1;
    end else if (out_busy_q && dig_o.ready) begin
      out_d      = out_q >> 32;
      out_idx_d  = out_idx_q + 3'd1;
      out_busy_d = (out_idx_q != 3'd4);
    end
  end

  assign dig_o.valid       = out_busy_q;
  assign dig_o.digest_word = out_q[0];
  assign dig_o.word_index  = out_idx_q;
  assign dig_o.last_word   = (out_idx_q == 3'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha1_pkg::ST_IDLE;
      byte_cnt_q <= '0;
      bit_cnt_q  <= '0;
      len_cnt_q  <= '0;
      out_idx_q  <= '0;
      out_busy_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      byte_cnt_q <= byte_cnt_d;
      bit_cnt_q  <= bit_cnt_d;
      len_cnt_q  <= len_cnt_d;
      out_idx_q  <= out_idx_d;
      out_busy_q <= out_busy_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    out_q <= out_d;
  end

  `SHA1_ASSERT(a_out_idx, out_busy_q |-> (out_idx_q <= 3'd4), "digest index out of range")
  `SHA1_ASSERT(a_fill_free, (push && (byte_cnt_q == 6'd63)) |-> !core_busy,
               "block filled while compressing")
  `SHA1_ASSERT_NEXT(a_snap_out, snap, out_busy_q && (out_idx_q == 3'd0),
                    "digest not presented after capture")

endmodule

`default_nettype wire

// ===== design/sha1_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 compression unit
// One round per cycle on a shared round datapath, 80 rounds, then the
// chaining add. The message schedule runs in a 16-word shift line.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha1_message_digest_defines.svh"

module sha1_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sha1_pkg::core_ctrl_t ctrl_i,
  input  sha1_pkg::block_t     block_i,
  output logic                 busy_o,
  output sha1_pkg::chain_t     chain_o
);

  localparam logic [6:0] LAST_ROUND = 7'(sha1_pkg::ROUNDS);

  sha1_pkg::chain_t chain_q, chain_d;
  sha1_pkg::chain_t work_q, work_d;
  sha1_pkg::word_t  win_q [sha1_pkg::BLOCK_WORDS];
  sha1_pkg::word_t  win_d [sha1_pkg::BLOCK_WORDS];
  logic [6:0]       round_q, round_d;
  logic             busy_q, busy_d;

  logic [1:0]       grp;
  sha1_pkg::word_t  f_val, t_val, w_new, w_mix;

  // round group select
  always_comb begin
    priority if (round_q < 7'd20) begin
      grp = 2'd0;
    end else if (round_q < 7'd40) begin
      grp = 2'd1;
    end else if (round_q < 7'd60) begin
      grp = 2'd2;
    end else begin
      grp = 2'd3;
    end
  end

  // round datapath: a=work[0] .. e=work[4]
  always_comb begin
    unique case (grp)
      2'd0:    f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      2'd2:    f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) |
                       (work_q[2] & work_q[3]);
      default: f_val = work_q[1] ^ work_q[2] ^ work_q[3];
    endcase
    t_val = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4] +
            sha1_pkg::round_const(grp) + win_q[0];
    w_mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    w_new = {w_mix[30:0], w_mix[31]};
  end

  // sequencing of load, rounds and chaining add
  always_comb begin
    chain_d = chain_q;
    work_d  = work_q;
    win_d   = win_q;
    round_d = round_q;
    busy_d  = busy_q;
    if (ctrl_i.init_chain) begin
      chain_d = sha1_pkg::chain_init();
    end else if (!busy_q && ctrl_i.start) begin
      work_d  = chain_q;
      for (int j = 0; j < sha1_pkg::BLOCK_WORDS; j++) begin
        win_d[j] = block_i[sha1_pkg::BLOCK_WORDS-1-j];
      end
      round_d = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (round_q == LAST_ROUND) begin
        for (int j = 0; j < sha1_pkg::WORDS; j++) begin
          chain_d[j] = chain_q[j] + work_q[j];
        end
        round_d = '0;
        busy_d  = 1'b0;
      end else begin
        work_d[4] = work_q[3];
        work_d[3] = work_q[2];
        work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
        work_d[1] = work_q[0];
        work_d[0] = t_val;
        for (int j = 0; j < sha1_pkg::BLOCK_WORDS-1; j++) begin
          win_d[j] = win_q[j+1];
        end
        win_d[sha1_pkg::BLOCK_WORDS-1] = w_new;
        round_d = round_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha1_pkg::chain_init();
      work_q  <= '0;
      round_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      chain_q <= chain_d;
      work_q  <= work_d;
      round_q <= round_d;
      busy_q  <= busy_d;
    end
  end

  // schedule window, no reset
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign busy_o  = busy_q;
  assign chain_o = chain_q;

  `SHA1_ASSERT(a_round_range, round_q <= LAST_ROUND, "round counter past last round")
  `SHA1_ASSERT(a_round_idle, (round_q != 7'd0) |-> busy_q, "round count while idle")
  `SHA1_ASSERT(a_start_idle, !(ctrl_i.start && busy_q), "block start while compressing")
  `SHA1_ASSERT_NEXT(a_finish, busy_q && (round_q == LAST_ROUND), !busy_q,
                    "compression did not finish after last round")

endmodule

`default_nettype wire

// ===== verif/sha1_message_digest_tb.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Sends byte requests, end markers and ignored kinds over the request channel.
// A local SHA-1 predictor queues the five digest words of each message, and
// every word that leaves the block is checked against the oldest one waiting.
// Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // kind value that the block ignores
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam sha1_pkg::word_t IV0 = 32'h67452301;
  localparam sha1_pkg::word_t IV1 = 32'hEFCDAB89;
  localparam sha1_pkg::word_t IV2 = 32'h98BADCFE;
  localparam sha1_pkg::word_t IV3 = 32'h10325476;
  localparam sha1_pkg::word_t IV4 = 32'hC3D2E1F0;
  localparam sha1_pkg::word_t RC0 = 32'h5A827999;
  localparam sha1_pkg::word_t RC1 = 32'h6ED9EBA1;
  localparam sha1_pkg::word_t RC2 = 32'h8F1BBCDC;
  localparam sha1_pkg::word_t RC3 = 32'hCA62C1D6;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    sha1_pkg::word_t value;
    logic [2:0]      index;
    logic            last;
  } digest_item_t;

  logic clk_i;
  logic rst_ni;

  sha1_req_if req_if ();
  sha1_dig_if dig_if ();

  sha1_message_digest u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .dig_o  (dig_if)
  );

  // predictor state
  sha1_pkg::word_t hash_state [5];
  logic [7:0]      block_bytes [64];
  int              block_fill;
  logic [63:0]     msg_bits;
  digest_item_t    digests_q [$];

  digest_item_t expected_digest;
  int           fail_count   = 0;
  int           cycle_count  = 0;
  int           stall_left   = 0;
  int           random_items = 0;
  bit           src_idle_en  = 1'b0;
  bit           snk_idle_en  = 1'b0;

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // SHA-1 predictor
  // ---------------------------------------------------------------------------
  function automatic void restart_hash();
    hash_state[0] = IV0;
    hash_state[1] = IV1;
    hash_state[2] = IV2;
    hash_state[3] = IV3;
    hash_state[4] = IV4;
    block_fill = 0;
    msg_bits = '0;
  endfunction

  // 80 rounds over the 64 buffered bytes, folded into the chaining words
  function automatic void compress_block();
    sha1_pkg::word_t w [80];
    sha1_pkg::word_t a, b, c, d, e, f, k, t;
    for (int j = 0; j < 16; j++)
      w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
    for (int j = 16; j < 80; j++) begin
      t = w[j-3] ^ w[j-8] ^ w[j-14] ^ w[j-16];
      w[j] = {t[30:0], t[31]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RC0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RC1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC2;
      end else begin
        f = b ^ c ^ d;
        k = RC3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    block_bytes[block_fill] = b;
    block_fill++;
    if (block_fill == 64) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // one accepted request; queues the digest words at the end of a message
  function automatic void absorb_request(input logic [1:0] kind, input logic [7:0] data);
    logic [63:0]  len;
    digest_item_t item;
    if (kind == KIND_NONE) return;
    if (kind != sha1_pkg::KIND_END) begin
      msg_bits += 64'd8;
      put_byte(data);
      if (kind == sha1_pkg::KIND_BYTE) return;
    end
    len = msg_bits;
    put_byte(sha1_pkg::PAD_MARK);
    // wraps through a second block when the marker lands past the length slot
    while (block_fill != int'(sha1_pkg::LEN_BYTE_POS)) put_byte(8'h00);
    for (int j = 0; j < 8; j++) put_byte(len[63-8*j -: 8]);
    for (int j = 0; j < 5; j++) begin
      item.value = hash_state[j];
      item.index = 3'(j);
      item.last  = (j == 4);
      digests_q.push_back(item);
    end
    restart_hash();
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [7:0] data);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid     <= 1'b1;
    req_if.kind      <= kind;
    req_if.data_byte <= data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    absorb_request(kind, data);
  endtask

  // len bytes of random content, closed by a last byte or by an end marker;
  // ignored requests are sprinkled in when noisy is set
  task automatic send_message(input int len, input bit use_marker, input bit noisy);
    logic [1:0] kind;
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 19) == 0)
        send_request(KIND_NONE, 8'($urandom_range(0, 255)));
      kind = (i == len - 1 && !use_marker) ? sha1_pkg::KIND_LAST : sha1_pkg::KIND_BYTE;
      send_request(kind, 8'($urandom_range(0, 255)));
      random_items++;
    end
    if (use_marker || len == 0) begin
      send_request(sha1_pkg::KIND_END, 8'($urandom_range(0, 255)));
      random_items++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Digest side: random stalls, checked against the oldest expected word
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      dig_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
      dig_if.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      dig_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      if (digests_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected digest word %h index %0d last %b", $realtime,
                   dig_if.digest_word, dig_if.word_index, dig_if.last_word);
      end else begin
        expected_digest = digests_q.pop_front();
        if (dig_if.digest_word !== expected_digest.value ||
            dig_if.word_index !== expected_digest.index ||
            dig_if.last_word !== expected_digest.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: digest mismatch: expected %h/%0d/%b, got %h/%0d/%b", $realtime,
                     expected_digest.value, expected_digest.index, expected_digest.last,
                     dig_if.digest_word, dig_if.word_index, dig_if.last_word);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // empty messages; the byte of an end marker must not matter
  task automatic test_empty_message();
    send_request(sha1_pkg::KIND_END, 8'hA5);
    send_request(sha1_pkg::KIND_END, 8'h00);
  endtask

  // "abc" and single-byte messages at the byte extremes
  task automatic test_short_messages();
    send_request(sha1_pkg::KIND_BYTE, 8'h61);
    send_request(sha1_pkg::KIND_BYTE, 8'h62);
    send_request(sha1_pkg::KIND_LAST, 8'h63);
    send_request(sha1_pkg::KIND_LAST, 8'h00);
    send_request(sha1_pkg::KIND_LAST, 8'hFF);
    send_request(sha1_pkg::KIND_BYTE, 8'hFF);
    send_request(sha1_pkg::KIND_END,  8'hFF);
  endtask

  // unused kind inside a message and while idle
  task automatic test_unused_kind();
    send_request(KIND_NONE, 8'hFF);
    send_request(sha1_pkg::KIND_BYTE, 8'h12);
    send_request(KIND_NONE, 8'h00);
    send_request(KIND_NONE, 8'hFF);
    send_request(sha1_pkg::KIND_LAST, 8'h34);
    send_request(KIND_NONE, 8'h5A);
  endtask

  // marker at 55 and 56 bytes: one or two padding blocks
  task automatic test_padding_boundaries();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    send_message(55, 1'b0, 1'b1);
    send_message(56, 1'b1, 1'b1);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
  endtask

  // random messages, mostly short, some around the block size
  task automatic test_random_messages();
    int len;
    while (random_items < 140) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0)
        len = $urandom_range(62, 66);
      else
        len = $urandom_range(0, 12);
      send_message(len, 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  initial begin
    restart_hash();
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.kind      = sha1_pkg::KIND_BYTE;
    req_if.data_byte = 8'h00;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_message();
    test_short_messages();
    test_unused_kind();
    test_padding_boundaries();
    test_random_messages();

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (digests_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && digests_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
